### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every edge outside reset.
`define HLPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence at the next edge.
`define HLPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/hlpd_pkg.sv
// ----------------------------------------------------------------------------
// hlpd_pkg
// Types and constants shared by the hopping leg phase PD controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hlpd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_H,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CH_A,
      CH_B,
      CH_HIP
   } chan_type;

   typedef enum logic [3:0] {
      REG_FLIGHT_STIFFNESS = 4'd0,
      REG_FLIGHT_DAMPING   = 4'd1,
      REG_STANCE_STIFFNESS = 4'd2,
      REG_STANCE_DAMPING   = 4'd3,
      REG_HIP_STIFFNESS    = 4'd4,
      REG_HIP_DAMPING      = 4'd5,
      REG_LEG_TARGET_ANGLE = 4'd6,
      REG_LEG_HALF_SPREAD  = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] flight_stiffness;
      logic [15:0] flight_damping;
      logic [15:0] stance_stiffness;
      logic [15:0] stance_damping;
      logic [15:0] hip_stiffness;
      logic [15:0] hip_damping;
      logic [15:0] leg_target_angle;
      logic [13:0] leg_half_spread;
   } csr_type;

   typedef struct packed {
      logic [15:0] torso_pitch;
      logic [15:0] hip_position;
      logic [15:0] hip_rate;
      logic [15:0] motor_a_position;
      logic [15:0] motor_b_position;
      logic [15:0] motor_a_rate;
      logic [15:0] motor_b_rate;
      logic [15:0] body_height;
      logic        toe_contact;
   } sample_type;

   typedef struct packed {
      logic     load_in;
      logic     mul_en;
      chan_type mul_ch;
      logic     hip_scale;
      logic     hip_clamp;
      logic     sum_en;
      logic     commit;
   } cmd_type;

   localparam logic [15:0] LEG_TARGET_RESET = 16'd6434;
   localparam logic [13:0] HALF_SPREAD_RESET = 14'd11019;

   localparam logic [14:0] HIP_SLOPE = 15'd32560;
   localparam logic signed [31:0] HIP_ROUND = 32'sd16384;
   localparam logic signed [17:0] HIP_OFFSET = 18'sd152;
   localparam logic signed [17:0] HIP_MIN = -18'sd822;
   localparam logic signed [17:0] HIP_MAX = 18'sd606;
   localparam logic signed [37:0] TORQUE_ROUND = 38'sd2048;
   localparam logic signed [15:0] TOUCHDOWN_HEIGHT = 16'sd3727;
   localparam logic signed [15:0] LIFTOFF_HEIGHT = 16'sd3687;
   localparam logic [7:0] STEPS_MAX = 8'd255;

endpackage

### src/hopping_leg_phase_pd_controller.sv
// ----------------------------------------------------------------------------
// hopping_leg_phase_pd_controller
// Flight/stance PD control of two leg motors and the hip, one tick per item.
// ----------------------------------------------------------------------------
// Channel  Prefix  Direction  Content
// input    req_    in         sensor readings of one control tick
// result   rsp_    out        three saturated torques and the new phase
// config   csr_    in         gain, target angle and spread writes
//
// One shared pair of PD multipliers serves motor A, motor B and the hip in
// turn, and the sum of each channel is formed from its registered products.
// A new item is taken in the cycle its predecessor's result is loaded.
// A held result stalls the sequencer only in its last step.
// Reset sets flight phase, clears the stance count and loads CSR defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hopping_leg_phase_pd_controller #(
   parameter int unsigned LIFTOFF_MIN_STEPS = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // torso_pitch, hip_position, hip_rate, motor_a_position, motor_b_position,
   // motor_a_rate, motor_b_rate, body_height, toe_contact, zero fill
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // drive_a, drive_b, drive_hip, airborne, zero fill
   output logic [55:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [3:0]    csr_index,
   input  logic [15:0]   csr_data
);

   hlpd_pkg::csr_type    regs;
   hlpd_pkg::cmd_type    cmd;
   hlpd_pkg::sample_type sample;
   logic [15:0]          drive_a;
   logic [15:0]          drive_b;
   logic [15:0]          drive_hip;
   logic                 airborne;

   assign sample.torso_pitch = req_tdata[15:0];
   assign sample.hip_position = req_tdata[31:16];
   assign sample.hip_rate = req_tdata[47:32];
   assign sample.motor_a_position = req_tdata[63:48];
   assign sample.motor_b_position = req_tdata[79:64];
   assign sample.motor_a_rate = req_tdata[95:80];
   assign sample.motor_b_rate = req_tdata[111:96];
   assign sample.body_height = req_tdata[127:112];
   assign sample.toe_contact = req_tdata[128];

   assign rsp_tdata = {7'b0, airborne, drive_hip, drive_b, drive_a};

   hlpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .regs      (regs)
   );

   hlpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   hlpd_datapath #(
      .LIFTOFF_MIN_STEPS (LIFTOFF_MIN_STEPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .regs      (regs),
      .sample    (sample),
      .drive_a   (drive_a),
      .drive_b   (drive_b),
      .drive_hip (drive_hip),
      .airborne  (airborne)
   );

   `HLPD_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_tvalid && req_tready, !req_tready, "input taken again right after a transfer")
   `HLPD_ASSERT(a_busy_through_multiply, clock, reset, (req_tvalid && req_tready) |=> ##2 !req_tready, "input taken before the hip products were formed")
   `HLPD_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_tvalid, "loaded result not presented")
   `HLPD_ASSERT(a_commit_needs_room, clock, reset, !(cmd.commit && rsp_tvalid && !rsp_tready), "result overwritten while held")

endmodule

### src/hlpd_csr.sv
// ----------------------------------------------------------------------------
// hlpd_csr
// Configuration register file for gains, leg target angle and leg spread.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlpd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_index,
   input  logic [15:0]      csr_data,
   output hlpd_pkg::csr_type regs
);

   hlpd_pkg::csr_type regs_ff;
   hlpd_pkg::csr_type regs_in;

   assign csr_ready = !reset;
   assign regs = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid && csr_ready) begin
         case (hlpd_pkg::csr_index_type'(csr_index))
            hlpd_pkg::REG_FLIGHT_STIFFNESS: regs_in.flight_stiffness = csr_data;
            hlpd_pkg::REG_FLIGHT_DAMPING:   regs_in.flight_damping = csr_data;
            hlpd_pkg::REG_STANCE_STIFFNESS: regs_in.stance_stiffness = csr_data;
            hlpd_pkg::REG_STANCE_DAMPING:   regs_in.stance_damping = csr_data;
            hlpd_pkg::REG_HIP_STIFFNESS:    regs_in.hip_stiffness = csr_data;
            hlpd_pkg::REG_HIP_DAMPING:      regs_in.hip_damping = csr_data;
            hlpd_pkg::REG_LEG_TARGET_ANGLE: regs_in.leg_target_angle = csr_data;
            hlpd_pkg::REG_LEG_HALF_SPREAD:  regs_in.leg_half_spread = csr_data[13:0];
            default: regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.flight_stiffness <= '0;
         regs_ff.flight_damping <= '0;
         regs_ff.stance_stiffness <= '0;
         regs_ff.stance_damping <= '0;
         regs_ff.hip_stiffness <= '0;
         regs_ff.hip_damping <= '0;
         regs_ff.leg_target_angle <= hlpd_pkg::LEG_TARGET_RESET;
         regs_ff.leg_half_spread <= hlpd_pkg::HALF_SPREAD_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

### src/hlpd_ctrl.sv
// ----------------------------------------------------------------------------
// hlpd_ctrl
// Sequencer for one control tick and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output hlpd_pkg::cmd_type cmd
);

   hlpd_pkg::state_type state_ff;
   hlpd_pkg::state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hlpd_pkg::ST_IDLE: begin
            if (req_tvalid && !reset) state_in = hlpd_pkg::ST_MUL_A;
         end
         hlpd_pkg::ST_MUL_A: state_in = hlpd_pkg::ST_MUL_B;
         hlpd_pkg::ST_MUL_B: state_in = hlpd_pkg::ST_MUL_H;
         hlpd_pkg::ST_MUL_H: state_in = hlpd_pkg::ST_FINISH;
         hlpd_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = req_tvalid ? hlpd_pkg::ST_MUL_A : hlpd_pkg::ST_IDLE;
            end
         end
         default: state_in = hlpd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_ch = hlpd_pkg::CH_A;
      req_tready = 1'b0;
      case (state_ff)
         hlpd_pkg::ST_IDLE: begin
            req_tready = !reset;
         end
         hlpd_pkg::ST_MUL_A: begin
            cmd.mul_en = 1'b1;
            cmd.mul_ch = hlpd_pkg::CH_A;
            cmd.hip_scale = 1'b1;
         end
         hlpd_pkg::ST_MUL_B: begin
            cmd.mul_en = 1'b1;
            cmd.mul_ch = hlpd_pkg::CH_B;
            cmd.hip_clamp = 1'b1;
            cmd.sum_en = 1'b1;
         end
         hlpd_pkg::ST_MUL_H: begin
            cmd.mul_en = 1'b1;
            cmd.mul_ch = hlpd_pkg::CH_HIP;
            cmd.sum_en = 1'b1;
         end
         hlpd_pkg::ST_FINISH: begin
            cmd.commit = out_free;
            req_tready = out_free && !reset;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.load_in = req_tready && req_tvalid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hlpd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/hlpd_datapath.sv
// ----------------------------------------------------------------------------
// hlpd_datapath
// Shared PD multiply pair, torque rounding and saturation, hip target
// scaling, and the flight/stance phase tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hlpd_datapath #(
   parameter int unsigned LIFTOFF_MIN_STEPS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hlpd_pkg::cmd_type    cmd,
   input  hlpd_pkg::csr_type    regs,
   input  hlpd_pkg::sample_type sample,
   output logic [15:0]          drive_a,
   output logic [15:0]          drive_b,
   output logic [15:0]          drive_hip,
   output logic                 airborne
);

   localparam logic [7:0] LIFT_STEPS = 8'(LIFTOFF_MIN_STEPS);

   hlpd_pkg::sample_type sample_ff;
   logic                 phase_ff;
   logic                 phase_in;
   logic [7:0]           steps_ff;
   logic [7:0]           steps_in;
   logic signed [31:0]   hip_prod_ff;
   logic signed [31:0]   hip_prod_in;
   logic signed [10:0]   hip_tgt_ff;
   logic signed [10:0]   hip_tgt_in;
   logic signed [34:0]   p_ff;
   logic signed [34:0]   p_in;
   logic signed [32:0]   d_ff;
   logic signed [32:0]   d_in;
   hlpd_pkg::chan_type   sum_ch_ff;
   logic [15:0]          work_a_ff;
   logic [15:0]          work_b_ff;
   logic [15:0]          out_a_ff;
   logic [15:0]          out_b_ff;
   logic [15:0]          out_h_ff;
   logic                 out_air_ff;

   logic [15:0]          kp;
   logic [15:0]          kd;
   logic signed [17:0]   tgt;
   logic [15:0]          pos;
   logic [15:0]          rate;
   logic signed [17:0]   err;
   logic signed [16:0]   kp_s;
   logic signed [16:0]   kd_s;
   logic signed [37:0]   sum_full;
   logic signed [25:0]   sum_q;
   logic [15:0]          torque_in;
   logic signed [31:0]   hip_sum;
   logic signed [17:0]   hip_off;
   logic signed [15:0]   height;
   logic                 touchdown;
   logic                 liftoff;

   assign drive_a = out_a_ff;
   assign drive_b = out_b_ff;
   assign drive_hip = out_h_ff;
   assign airborne = out_air_ff;

   always_comb begin
      kp = phase_ff ? regs.flight_stiffness : regs.stance_stiffness;
      kd = phase_ff ? regs.flight_damping : regs.stance_damping;
      tgt = $signed({{2{regs.leg_target_angle[15]}}, regs.leg_target_angle})
            - $signed({4'b0, regs.leg_half_spread});
      pos = sample_ff.motor_a_position;
      rate = sample_ff.motor_a_rate;
      case (cmd.mul_ch)
         hlpd_pkg::CH_A: begin
            pos = sample_ff.motor_a_position;
         end
         hlpd_pkg::CH_B: begin
            tgt = $signed({{2{regs.leg_target_angle[15]}}, regs.leg_target_angle})
                  + $signed({4'b0, regs.leg_half_spread});
            pos = sample_ff.motor_b_position;
            rate = sample_ff.motor_b_rate;
         end
         hlpd_pkg::CH_HIP: begin
            kp = regs.hip_stiffness;
            kd = regs.hip_damping;
            tgt = {{7{hip_tgt_ff[10]}}, hip_tgt_ff};
            pos = sample_ff.hip_position;
            rate = sample_ff.hip_rate;
         end
         default: begin
            pos = sample_ff.motor_a_position;
         end
      endcase
      err = tgt - $signed({{2{pos[15]}}, pos});
      kp_s = $signed({1'b0, kp});
      kd_s = $signed({1'b0, kd});
      p_in = kp_s * err;
      d_in = kd_s * $signed(rate);
   end

   always_comb begin
      sum_full = $signed({{3{p_ff[34]}}, p_ff}) - $signed({d_ff[32], d_ff, 4'b0})
                 + hlpd_pkg::TORQUE_ROUND;
      sum_q = sum_full[37:12];
      if (sum_q[25:15] != {11{sum_q[25]}}) begin
         torque_in = sum_q[25] ? 16'h8000 : 16'h7FFF;
      end else begin
         torque_in = sum_q[15:0];
      end
   end

   always_comb begin
      hip_prod_in = $signed({1'b0, hlpd_pkg::HIP_SLOPE}) * $signed(sample_ff.torso_pitch);
      hip_sum = hip_prod_ff + hlpd_pkg::HIP_ROUND;
      hip_off = $signed({hip_sum[31], hip_sum[31:15]}) + hlpd_pkg::HIP_OFFSET;
      if (hip_off < hlpd_pkg::HIP_MIN) begin
         hip_tgt_in = hlpd_pkg::HIP_MIN[10:0];
      end else if (hip_off > hlpd_pkg::HIP_MAX) begin
         hip_tgt_in = hlpd_pkg::HIP_MAX[10:0];
      end else begin
         hip_tgt_in = hip_off[10:0];
      end
   end

   always_comb begin
      height = $signed(sample_ff.body_height);
      touchdown = (height <= hlpd_pkg::TOUCHDOWN_HEIGHT) && sample_ff.toe_contact;
      liftoff = (steps_ff > LIFT_STEPS) && (height >= hlpd_pkg::LIFTOFF_HEIGHT)
                && !sample_ff.toe_contact;
      phase_in = phase_ff;
      steps_in = steps_ff;
      if (phase_ff) begin
         if (touchdown) begin
            phase_in = 1'b0;
            steps_in = '0;
         end
      end else begin
         if (liftoff) phase_in = 1'b1;
         if (steps_ff != hlpd_pkg::STEPS_MAX) steps_in = steps_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b1;
         steps_ff <= '0;
      end else if (cmd.commit) begin
         phase_ff <= phase_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) sample_ff <= sample;
      if (cmd.hip_scale) hip_prod_ff <= hip_prod_in;
      if (cmd.hip_clamp) hip_tgt_ff <= hip_tgt_in;
      if (cmd.mul_en) begin
         p_ff <= p_in;
         d_ff <= d_in;
         sum_ch_ff <= cmd.mul_ch;
      end
      if (cmd.sum_en) begin
         if (sum_ch_ff == hlpd_pkg::CH_A) work_a_ff <= torque_in;
         if (sum_ch_ff == hlpd_pkg::CH_B) work_b_ff <= torque_in;
      end
      if (cmd.commit) begin
         out_a_ff <= work_a_ff;
         out_b_ff <= work_b_ff;
         out_h_ff <= torque_in;
         out_air_ff <= phase_in;
      end
   end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hopping leg phase PD controller. Sensor ticks
// are streamed in and a local predictor of the flight and stance phases
// computes the expected torques and phase. Each result transfer is compared
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int STANCE_TICKS_MIN = 10;
   localparam int HIP_SLOPE_Q15 = 32560;
   localparam int HIP_BIAS_Q12 = 152;
   localparam int HIP_LOW_Q12 = -822;
   localparam int HIP_HIGH_Q12 = 606;
   localparam int TOUCHDOWN_Q12 = 3727;
   localparam int LIFTOFF_Q12 = 3687;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [3:0] FIRST_UNUSED_INDEX = 4'(hlpd_pkg::REG_LEG_HALF_SPREAD) + 4'd1;

   typedef struct {
      logic signed [15:0] drive_a;
      logic signed [15:0] drive_b;
      logic signed [15:0] drive_hip;
      logic               airborne;
   } drive_set_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   hlpd_pkg::csr_type ctrl_regs;
   logic         phase_airborne;
   logic [7:0]   stance_ticks;
   drive_set_type expected_drives[$];
   int           fail_count = 0;
   int           ticks_sent = 0;
   int           sender_idle_pct = 0;
   int           receiver_idle_pct = 0;
   int           rsp_hold_left = 0;

   hopping_leg_phase_pd_controller #(
      .LIFTOFF_MIN_STEPS(STANCE_TICKS_MIN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [135:0] pack_tick(input hlpd_pkg::sample_type s);
      return {7'b0, s.toe_contact, s.body_height, s.motor_b_rate, s.motor_a_rate,
              s.motor_b_position, s.motor_a_position, s.hip_rate, s.hip_position,
              s.torso_pitch};
   endfunction

   function automatic logic [15:0] pd_drive(input logic [15:0] kp, input logic [15:0] kd,
                                            input longint target, input longint pos,
                                            input longint rate);
      longint t;
      t = (longint'(kp) * (target - pos) - longint'(kd) * rate * 16 + 2048) >>> 12;
      if (t > 32767) begin
         t = 32767;
      end else if (t < -32768) begin
         t = -32768;
      end
      return t[15:0];
   endfunction

   function automatic drive_set_type predict_tick(input hlpd_pkg::sample_type s);
      drive_set_type r;
      logic [15:0] kp;
      logic [15:0] kd;
      longint tgt_a;
      longint tgt_b;
      longint hip_tgt;
      longint height;
      kp = phase_airborne ? ctrl_regs.flight_stiffness : ctrl_regs.stance_stiffness;
      kd = phase_airborne ? ctrl_regs.flight_damping : ctrl_regs.stance_damping;
      tgt_a = longint'($signed(ctrl_regs.leg_target_angle)) - longint'(ctrl_regs.leg_half_spread);
      tgt_b = longint'($signed(ctrl_regs.leg_target_angle)) + longint'(ctrl_regs.leg_half_spread);
      hip_tgt = ((longint'(HIP_SLOPE_Q15) * longint'($signed(s.torso_pitch)) + 16384) >>> 15)
                + HIP_BIAS_Q12;
      if (hip_tgt < HIP_LOW_Q12) begin
         hip_tgt = HIP_LOW_Q12;
      end
      if (hip_tgt > HIP_HIGH_Q12) begin
         hip_tgt = HIP_HIGH_Q12;
      end
      r.drive_a = pd_drive(kp, kd, tgt_a, $signed(s.motor_a_position), $signed(s.motor_a_rate));
      r.drive_b = pd_drive(kp, kd, tgt_b, $signed(s.motor_b_position), $signed(s.motor_b_rate));
      r.drive_hip = pd_drive(ctrl_regs.hip_stiffness, ctrl_regs.hip_damping, hip_tgt,
                             $signed(s.hip_position), $signed(s.hip_rate));
      height = $signed(s.body_height);
      if (phase_airborne) begin
         if (height <= TOUCHDOWN_Q12 && s.toe_contact) begin
            phase_airborne = 1'b0;
            stance_ticks = 8'd0;
         end
      end else begin
         if (stance_ticks > STANCE_TICKS_MIN && height >= LIFTOFF_Q12 && !s.toe_contact) begin
            phase_airborne = 1'b1;
         end
         if (stance_ticks != 8'hFF) begin
            stance_ticks++;
         end
      end
      r.airborne = phase_airborne;
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : check_drives
      drive_set_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drives.size() == 0) begin
            $error("result transfer with no tick pending");
            fail_count++;
         end else begin
            want = expected_drives.pop_front();
            check_field("drive_a", want.drive_a, $signed(rsp_tdata[15:0]));
            check_field("drive_b", want.drive_b, $signed(rsp_tdata[31:16]));
            check_field("drive_hip", want.drive_hip, $signed(rsp_tdata[47:32]));
            check_field("airborne", want.airborne, rsp_tdata[48]);
         end
      end
   end

   task automatic send_tick(input hlpd_pkg::sample_type s);
      req_tdata <= pack_tick(s);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_drives.push_back(predict_tick(s));
      ticks_sent++;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drives();
      req_tvalid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [3:0] idx, input logic [15:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         hlpd_pkg::REG_FLIGHT_STIFFNESS: ctrl_regs.flight_stiffness = value;
         hlpd_pkg::REG_FLIGHT_DAMPING:   ctrl_regs.flight_damping = value;
         hlpd_pkg::REG_STANCE_STIFFNESS: ctrl_regs.stance_stiffness = value;
         hlpd_pkg::REG_STANCE_DAMPING:   ctrl_regs.stance_damping = value;
         hlpd_pkg::REG_HIP_STIFFNESS:    ctrl_regs.hip_stiffness = value;
         hlpd_pkg::REG_HIP_DAMPING:      ctrl_regs.hip_damping = value;
         hlpd_pkg::REG_LEG_TARGET_ANGLE: ctrl_regs.leg_target_angle = value;
         hlpd_pkg::REG_LEG_HALF_SPREAD:  ctrl_regs.leg_half_spread = value[13:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_registers(input logic [15:0] fk, input logic [15:0] fd,
                                 input logic [15:0] sk, input logic [15:0] sd,
                                 input logic [15:0] hk, input logic [15:0] hd,
                                 input logic [15:0] target, input logic [15:0] spread);
      write_csr(hlpd_pkg::REG_FLIGHT_STIFFNESS, fk);
      write_csr(hlpd_pkg::REG_FLIGHT_DAMPING, fd);
      write_csr(hlpd_pkg::REG_STANCE_STIFFNESS, sk);
      write_csr(hlpd_pkg::REG_STANCE_DAMPING, sd);
      write_csr(hlpd_pkg::REG_HIP_STIFFNESS, hk);
      write_csr(hlpd_pkg::REG_HIP_DAMPING, hd);
      write_csr(hlpd_pkg::REG_LEG_TARGET_ANGLE, target);
      write_csr(hlpd_pkg::REG_LEG_HALF_SPREAD, spread);
      write_csr(FIRST_UNUSED_INDEX + 4'($urandom_range(7)), 16'($urandom));
   endtask

   function automatic logic [15:0] random_reg_value();
      case ($urandom_range(3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1023));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] sensor_value();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(4095)) - 16'd2048;
      endcase
   endfunction

   function automatic hlpd_pkg::sample_type random_tick();
      hlpd_pkg::sample_type s;
      s.torso_pitch = sensor_value();
      s.hip_position = sensor_value();
      s.hip_rate = sensor_value();
      s.motor_a_position = sensor_value();
      s.motor_b_position = sensor_value();
      s.motor_a_rate = sensor_value();
      s.motor_b_rate = sensor_value();
      s.body_height = sensor_value();
      s.toe_contact = 1'($urandom_range(1));
      return s;
   endfunction

   function automatic logic [15:0] height_at_or_above(input int limit);
      return 16'(limit + $urandom_range($urandom_range(1) ? 64 : 32767 - limit));
   endfunction

   function automatic logic [15:0] height_at_or_below(input int limit);
      return 16'(limit - $urandom_range($urandom_range(1) ? 64 : limit + 32768));
   endfunction

   task automatic send_shaped(input logic [15:0] height, input logic toe);
      hlpd_pkg::sample_type s;
      s = random_tick();
      s.body_height = height;
      s.toe_contact = toe;
      send_tick(s);
   endtask

   task automatic send_stance_tick();
      if ($urandom_range(1)) begin
         send_shaped(sensor_value(), 1'b1);
      end else begin
         send_shaped(height_at_or_below(LIFTOFF_Q12 - 1), 1'b0);
      end
   endtask

   task automatic run_hop();
      repeat ($urandom_range(4, 1)) begin
         if ($urandom_range(1)) begin
            send_shaped(height_at_or_above(TOUCHDOWN_Q12 + 1), 1'($urandom_range(1)));
         end else begin
            send_shaped(sensor_value(), 1'b0);
         end
      end
      send_shaped(height_at_or_below(TOUCHDOWN_Q12), 1'b1);
      repeat ($urandom_range(16, 6)) send_stance_tick();
      send_shaped(height_at_or_above(LIFTOFF_Q12), 1'b0);
   endtask

   task automatic test_reset_values();
      hlpd_pkg::sample_type s;
      s = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
            16'h7FFF, 1'b1};
      send_tick(s);
      s = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 1'b0};
      send_tick(s);
      wait_for_drives();
   endtask

   task automatic test_phase_transitions();
      load_registers(16'h0180, 16'h0020, 16'h0300, 16'h0008, 16'h0200, 16'h0010,
                     16'd6434, 16'hC000 | 16'd11019);
      send_shaped(16'(TOUCHDOWN_Q12 + 1), 1'b1);
      send_shaped(16'(TOUCHDOWN_Q12), 1'b0);
      send_shaped(16'(TOUCHDOWN_Q12), 1'b1);
      repeat (STANCE_TICKS_MIN) send_shaped(height_at_or_above(LIFTOFF_Q12), 1'b1);
      send_shaped(16'(LIFTOFF_Q12), 1'b0);
      send_shaped(16'(LIFTOFF_Q12 - 1), 1'b0);
      send_shaped(16'(LIFTOFF_Q12), 1'b1);
      send_shaped(16'(LIFTOFF_Q12), 1'b0);
      wait_for_drives();
   endtask

   task automatic test_extreme_values();
      hlpd_pkg::sample_type hi;
      hlpd_pkg::sample_type lo;
      hlpd_pkg::sample_type mid;
      hi = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             16'h7FFF, 1'b1};
      lo = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
             16'h8000, 1'b0};
      mid = '0;
      load_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'h8000, 16'h0000);
      send_tick(hi);
      send_tick(lo);
      send_tick(mid);
      wait_for_drives();
      load_registers(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                     16'h7FFF, 16'hFFFF);
      send_tick(hi);
      send_tick(lo);
      wait_for_drives();
   endtask

   task automatic test_random_hops(input int tick_goal);
      int first;
      load_registers(random_reg_value(), random_reg_value(), random_reg_value(),
                     random_reg_value(), random_reg_value(), random_reg_value(),
                     random_reg_value(), random_reg_value());
      first = ticks_sent;
      while (ticks_sent - first < tick_goal) begin
         if ($urandom_range(9) < 7) begin
            run_hop();
         end else begin
            repeat ($urandom_range(3, 1)) send_tick(random_tick());
         end
      end
      wait_for_drives();
   endtask

   task automatic test_stance_count_saturation();
      send_shaped(height_at_or_below(TOUCHDOWN_Q12), 1'b1);
      repeat (265) send_stance_tick();
      send_shaped(height_at_or_above(LIFTOFF_Q12), 1'b0);
      wait_for_drives();
   endtask

   task automatic test_backpressure();
      rsp_hold_left = 200;
      repeat (24) send_tick(random_tick());
      wait_for_drives();
      repeat (10) send_tick(random_tick());
      wait_for_drives();
   endtask

   initial begin
      ctrl_regs = '{default: '0};
      ctrl_regs.leg_target_angle = hlpd_pkg::LEG_TARGET_RESET;
      ctrl_regs.leg_half_spread = hlpd_pkg::HALF_SPREAD_RESET;
      phase_airborne = 1'b1;
      stance_ticks = 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_phase_transitions();
      test_extreme_values();

      sender_idle_pct = 28;
      receiver_idle_pct = 61;
      test_random_hops(40);
      sender_idle_pct = 61;
      receiver_idle_pct = 28;
      test_random_hops(40);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_hops(40);
      test_stance_count_saturation();
      test_backpressure();

      wait_for_drives();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
